FILE: sv/dtdiff_pkg.sv
// Shared types, widths and calendar helper functions for the date difference block.
package dtdiff_pkg;

  localparam int unsigned DAY_W        = 5;
  localparam int unsigned MON_W        = 4;
  localparam int unsigned YEAR_W       = 14;
  localparam int unsigned YY_W         = 15;   // year + offset, March-based
  localparam int unsigned Q_W          = 9;    // quotient of a 13-bit value by 25
  localparam int unsigned MOFF_W       = 9;    // days before a month, March-based
  localparam int unsigned DN_W         = 23;   // day number from the epoch
  localparam int unsigned DIFF_W       = 23;
  localparam int unsigned WD_W         = 3;
  localparam int unsigned YEAR_OFFSET  = 400;
  localparam int unsigned DEF_MAX_YEAR = 9999;
  localparam int unsigned RECIP25      = 5243; // ceil(2^17 / 25)
  localparam int unsigned RECIP25_SH   = 17;
  localparam int unsigned WD_BIAS      = 3;    // day number + 3 mod 7 gives 0 = Sunday

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  typedef struct packed {
    logic              valid;
    logic [WD_W-1:0]   wd;
    logic [DN_W-1:0]   dn;
  } lane_res_t;

  // floor(x / 25), exact for every 13-bit x
  function automatic logic [Q_W-1:0] div25(input logic [12:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'(RECIP25);
    return Q_W'(p >> RECIP25_SH);
  endfunction

  // days from March 1 to the first of the month
  function automatic logic [MOFF_W-1:0] month_offset(input logic [MON_W-1:0] m);
    logic [MOFF_W-1:0] r;
    unique case (m)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2:                    r = leap ? 5'd29 : 5'd28;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

  // mod 7 by folding octal digits (8 = 1 mod 7)
  function automatic logic [WD_W-1:0] mod7(input logic [DN_W-1:0] x);
    logic [23:0] xe;
    logic [5:0]  s1;
    logic [3:0]  s2;
    logic [3:0]  s3;
    xe = 24'(x);
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 6'(xe[3*i +: 3]);
    end
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    return (s3 >= 4'd7) ? WD_W'(s3 - 4'd7) : WD_W'(s3);
  endfunction

endpackage

FILE: sv/dtdiff_lane.sv
// One date lane: validity check, day number and weekday over three stages.
module dtdiff_lane #(
  parameter int unsigned MAX_YEAR = dtdiff_pkg::DEF_MAX_YEAR
) (
  input  logic                            clk,
  input  dtdiff_pkg::pipe_en_t            en,
  input  logic [dtdiff_pkg::DAY_W-1:0]    day,
  input  logic [dtdiff_pkg::MON_W-1:0]    month,
  input  logic [dtdiff_pkg::YEAR_W-1:0]   year,
  output dtdiff_pkg::lane_res_t           res
);
  import dtdiff_pkg::*;

  localparam logic [YEAR_W-1:0] MaxYearW = YEAR_W'(MAX_YEAR);

  // stage 1: March-based year and quotients by 100 and 400
  logic [DAY_W-1:0]  day_s1_r,  day_s1_nxt;
  logic [MON_W-1:0]  mon_s1_r,  mon_s1_nxt;
  logic [YEAR_W-1:0] year_s1_r, year_s1_nxt;
  logic [YY_W-1:0]   yy_s1_r,   yy_s1_nxt;
  logic [Q_W-1:0]    q100_s1_r, q100_s1_nxt;
  logic [Q_W-1:0]    q400_s1_r, q400_s1_nxt;
  logic [Q_W-1:0]    qy_s1_r,   qy_s1_nxt;

  always_comb begin
    day_s1_nxt  = day;
    mon_s1_nxt  = month;
    year_s1_nxt = year;
    yy_s1_nxt   = YY_W'(year) + YY_W'(YEAR_OFFSET) - ((month <= 4'd2) ? 15'd1 : 15'd0);
    q100_s1_nxt = div25(yy_s1_nxt[YY_W-1:2]);
    q400_s1_nxt = div25(13'(yy_s1_nxt[YY_W-1:4]));
    qy_s1_nxt   = div25(13'(year[YEAR_W-1:2]));
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      day_s1_r  <= day_s1_nxt;
      mon_s1_r  <= mon_s1_nxt;
      year_s1_r <= year_s1_nxt;
      yy_s1_r   <= yy_s1_nxt;
      q100_s1_r <= q100_s1_nxt;
      q400_s1_r <= q400_s1_nxt;
      qy_s1_r   <= qy_s1_nxt;
    end
  end

  // stage 2: leap year, validity, day number
  logic            valid_s2_r, valid_s2_nxt;
  logic [DN_W-1:0] dn_s2_r,    dn_s2_nxt;
  logic            cent;
  logic            leap;
  logic [23:0]     dn_sum;

  always_comb begin
    cent = (year_s1_r[YEAR_W-1:2] == 12'({3'b0, qy_s1_r} * 12'd25));
    leap = (year_s1_r[1:0] == 2'b00) && (!cent || (qy_s1_r[1:0] == 2'b00));
    valid_s2_nxt = (mon_s1_r >= 4'd1) && (mon_s1_r <= 4'd12) && (day_s1_r != '0) &&
                   (year_s1_r <= MaxYearW) && (day_s1_r <= month_len(mon_s1_r, leap));
    dn_sum = 24'(yy_s1_r) * 24'd365 + 24'(yy_s1_r[YY_W-1:2]) + 24'(q400_s1_r)
           + 24'(month_offset(mon_s1_r)) + 24'(day_s1_r) - 24'd1 - 24'(q100_s1_r);
    dn_s2_nxt = dn_sum[DN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      valid_s2_r <= valid_s2_nxt;
      dn_s2_r    <= dn_s2_nxt;
    end
  end

  // stage 3: weekday
  lane_res_t res_s3_r, res_s3_nxt;

  always_comb begin
    res_s3_nxt.valid = valid_s2_r;
    res_s3_nxt.dn    = dn_s2_r;
    res_s3_nxt.wd    = mod7(dn_s2_r + DN_W'(WD_BIAS));
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      res_s3_r <= res_s3_nxt;
    end
  end

  assign res = res_s3_r;

endmodule

FILE: sv/dtdiff_merge.sv
// Merge stage: signed difference with saturation, zeroing on invalid dates.
module dtdiff_merge (
  input  logic                                 clk,
  input  dtdiff_pkg::pipe_en_t                 en,
  input  dtdiff_pkg::lane_res_t                res_a,
  input  dtdiff_pkg::lane_res_t                res_b,
  output logic signed [dtdiff_pkg::DIFF_W-1:0] day_difference,
  output logic [dtdiff_pkg::WD_W-1:0]          weekday_a,
  output logic [dtdiff_pkg::WD_W-1:0]          weekday_b,
  output logic                                 valid_a,
  output logic                                 valid_b
);
  import dtdiff_pkg::*;

  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic [WD_W-1:0]          wa_r, wa_nxt;
  logic [WD_W-1:0]          wb_r, wb_nxt;
  logic                     va_r, vb_r;
  logic [DN_W:0]            raw;
  logic                     both;

  always_comb begin
    both = res_a.valid && res_b.valid;
    raw  = {1'b0, res_b.dn} - {1'b0, res_a.dn};
    if (raw[DN_W] != raw[DN_W-1]) begin
      // overflow: clamp to the signed limits
      diff_nxt = raw[DN_W] ? {1'b1, {(DIFF_W-1){1'b0}}} : {1'b0, {(DIFF_W-1){1'b1}}};
    end else begin
      diff_nxt = raw[DIFF_W-1:0];
    end
    if (!both) begin
      diff_nxt = '0;
    end
    wa_nxt = both ? res_a.wd : '0;
    wb_nxt = both ? res_b.wd : '0;
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      diff_r <= diff_nxt;
      wa_r   <= wa_nxt;
      wb_r   <= wb_nxt;
      va_r   <= res_a.valid;
      vb_r   <= res_b.valid;
    end
  end

  assign day_difference = diff_r;
  assign weekday_a      = wa_r;
  assign weekday_b      = wb_r;
  assign valid_a        = va_r;
  assign valid_b        = vb_r;

endmodule

FILE: sv/date_difference_weekday.sv
// Pipeline: an accepted input transaction passes 3 lane stages + merge before output valid.
// Throughput: one date pair per cycle while out_stall is low; every stage is a register with its own valid bit.
// Each stage loads when empty or when the next stage drains, so bubbles close up under stall.
// Reset (rst_n low, synchronous) empties all stages; payload registers are not reset.
// Two lanes, one per date, run in parallel; the merge stage forms the difference.
module date_difference_weekday #(
  parameter int unsigned MAX_YEAR = dtdiff_pkg::DEF_MAX_YEAR
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dtdiff_pkg::DAY_W-1:0]         in_day_a,
  input  logic [dtdiff_pkg::MON_W-1:0]         in_month_a,
  input  logic [dtdiff_pkg::YEAR_W-1:0]        in_year_a,
  input  logic [dtdiff_pkg::DAY_W-1:0]         in_day_b,
  input  logic [dtdiff_pkg::MON_W-1:0]         in_month_b,
  input  logic [dtdiff_pkg::YEAR_W-1:0]        in_year_b,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dtdiff_pkg::DIFF_W-1:0] out_day_difference,
  output logic [dtdiff_pkg::WD_W-1:0]          out_weekday_a,
  output logic [dtdiff_pkg::WD_W-1:0]          out_weekday_b,
  output logic                                 out_valid_a,
  output logic                                 out_valid_b
);
  import dtdiff_pkg::*;

  // stage occupancy
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  logic v4_r, v4_nxt;   // output register

  // a stage can take data when it is empty or its content moves on this cycle
  logic rdy1, rdy2, rdy3, rdy4;
  pipe_en_t en;

  always_comb begin
    rdy4 = !v4_r || !out_stall;
    rdy3 = !v3_r || rdy4;
    rdy2 = !v2_r || rdy3;
    rdy1 = !v1_r || rdy2;

    en.s1 = rdy1 && in_valid;
    en.s2 = rdy2 && v1_r;
    en.s3 = rdy3 && v2_r;
    en.s4 = rdy4 && v3_r;

    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? v1_r     : v2_r;
    v3_nxt = rdy3 ? v2_r     : v3_r;
    v4_nxt = rdy4 ? v3_r     : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  assign in_stall  = !rdy1;
  assign out_valid = v4_r;

  lane_res_t res_a, res_b;

  // lane for the first date
  dtdiff_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_a (
    .clk   (clk),
    .en    (en),
    .day   (in_day_a),
    .month (in_month_a),
    .year  (in_year_a),
    .res   (res_a)
  );

  // lane for the second date
  dtdiff_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_b (
    .clk   (clk),
    .en    (en),
    .day   (in_day_b),
    .month (in_month_b),
    .year  (in_year_b),
    .res   (res_b)
  );

  // combine both lanes into the result transaction
  dtdiff_merge u_merge (
    .clk            (clk),
    .en             (en),
    .res_a          (res_a),
    .res_b          (res_b),
    .day_difference (out_day_difference),
    .weekday_a      (out_weekday_a),
    .weekday_b      (out_weekday_b),
    .valid_a        (out_valid_a),
    .valid_b        (out_valid_b)
  );

endmodule
